// ===== rtl/ctc_pkg.sv =====
package ctc_pkg;

  // Sizes of the decoder
  localparam int MAX_CLASSES  = 128;
  localparam int MAX_STEPS    = 32;
  localparam int SCORE_W      = 16;
  localparam int CLASS_W      = $clog2(MAX_CLASSES);
  localparam int STEP_W       = $clog2(MAX_STEPS);

  // Register fields
  localparam int CLASS_COUNT_W = 8;
  localparam int STEP_COUNT_W  = 6;
  localparam logic [CLASS_COUNT_W-1:0] CLASS_COUNT_RESET = CLASS_COUNT_W'(79);
  localparam logic [STEP_COUNT_W-1:0]  STEP_COUNT_RESET  = STEP_COUNT_W'(18);

  // Register map
  localparam int REG_COUNT = 2;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = $clog2(4 * REG_COUNT);
  localparam logic REG_CLASS_COUNT = 1'b0;
  localparam logic REG_STEP_COUNT  = 1'b1;

  // Step queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Decoded configuration seen by the front
  typedef struct packed {
    logic [CLASS_W-1:0] blank;
    logic [STEP_W-1:0]  last_step_idx;
  } dec_cfg_t;

  // Winner of one finished step
  typedef struct packed {
    logic [CLASS_W-1:0] winner;
    logic               is_blank;
    logic               last_step;
  } step_evt_t;

endpackage

// ===== rtl/ctc_greedy_decoder.sv =====
// Greedy CTC decoder. Class scores (signed Q8.8) stream in one per transaction,
// classes 0 .. class_count-1 of a time step in order, then the next step. The
// highest score of each step wins (the lower class on a tie); the last class is
// the blank. A label comes out when the winner is not blank and differs from the
// winner of the previous step; the final step of a sequence (step_count steps)
// always gives a transaction with sequence_end set. Rate: one score per cycle,
// set by the single compare-and-update in the front, while the queue is not
// full. A step winner goes into the queue, then to the output register; a two-entry
// queue lets the front keep taking scores while a result waits on out_ready.
// class_count is clamped to 2..128 and step_count to 1..32. Registers: class_count
// at 0x0, step_count at 0x4; write them only while the decoder is idle.
module ctc_greedy_decoder (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ctc_pkg::ADDR_W-1:0]           paddr,
  input  logic [ctc_pkg::DATA_W-1:0]           pwdata,
  output logic [ctc_pkg::DATA_W-1:0]           prdata,
  output logic                                 pready,
  // Score input
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [ctc_pkg::SCORE_W-1:0]   in_score,
  // Label output
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ctc_pkg::CLASS_W-1:0]          out_label,
  output logic                                 out_label_present,
  output logic                                 out_sequence_end
);

  localparam logic [ctc_pkg::CLASS_COUNT_W-1:0] MinClasses = ctc_pkg::CLASS_COUNT_W'(2);
  localparam logic [ctc_pkg::CLASS_COUNT_W-1:0] MaxClasses =
    ctc_pkg::CLASS_COUNT_W'(ctc_pkg::MAX_CLASSES);
  localparam logic [ctc_pkg::STEP_COUNT_W-1:0]  MaxSteps =
    ctc_pkg::STEP_COUNT_W'(ctc_pkg::MAX_STEPS);

  logic [ctc_pkg::CLASS_COUNT_W-1:0] class_count_r;
  logic [ctc_pkg::STEP_COUNT_W-1:0]  step_count_r;

  logic                              wr_en;
  logic                              reg_sel;
  logic [ctc_pkg::CLASS_COUNT_W-1:0] eff_classes;
  logic [ctc_pkg::STEP_COUNT_W-1:0]  eff_steps;
  ctc_pkg::dec_cfg_t                 dec_cfg;

  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  ctc_pkg::step_evt_t q_push_data;
  ctc_pkg::step_evt_t q_pop_data;

  // Register access
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_count_r <= ctc_pkg::CLASS_COUNT_RESET;
      step_count_r  <= ctc_pkg::STEP_COUNT_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        ctc_pkg::REG_CLASS_COUNT: class_count_r <= pwdata[ctc_pkg::CLASS_COUNT_W-1:0];
        ctc_pkg::REG_STEP_COUNT:  step_count_r  <= pwdata[ctc_pkg::STEP_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ctc_pkg::REG_CLASS_COUNT: prdata = ctc_pkg::DATA_W'(class_count_r);
      ctc_pkg::REG_STEP_COUNT:  prdata = ctc_pkg::DATA_W'(step_count_r);
      default:                  prdata = '0;
    endcase
  end

  // Clamp the counts and derive the blank class and last step index
  always_comb begin
    priority if (class_count_r < MinClasses) begin
      eff_classes = MinClasses;
    end else if (class_count_r > MaxClasses) begin
      eff_classes = MaxClasses;
    end else begin
      eff_classes = class_count_r;
    end
    priority if (step_count_r == '0) begin
      eff_steps = ctc_pkg::STEP_COUNT_W'(1);
    end else if (step_count_r > MaxSteps) begin
      eff_steps = MaxSteps;
    end else begin
      eff_steps = step_count_r;
    end
  end

  assign dec_cfg.blank         = ctc_pkg::CLASS_W'(eff_classes - 1'b1);
  assign dec_cfg.last_step_idx = ctc_pkg::STEP_W'(eff_steps - 1'b1);

  ctc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (dec_cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_score    (in_score),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  ctc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  ctc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_data            (q_pop_data),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_label         (out_label),
    .out_label_present (out_label_present),
    .out_sequence_end  (out_sequence_end)
  );

endmodule

// ===== rtl/ctc_front.sv =====
module ctc_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ctc_pkg::dec_cfg_t                   cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ctc_pkg::SCORE_W-1:0]  in_score,
  input  logic                                q_full,
  output logic                                q_push,
  output ctc_pkg::step_evt_t                  q_push_data
);

  logic signed [ctc_pkg::SCORE_W-1:0] best_score_r;
  logic [ctc_pkg::CLASS_W-1:0]        best_class_r;
  logic [ctc_pkg::CLASS_W-1:0]        class_idx_r;
  logic [ctc_pkg::STEP_W-1:0]         step_idx_r;

  logic                        accept;
  logic                        better;
  logic                        step_end;
  logic                        last_step;
  logic [ctc_pkg::CLASS_W-1:0] cur_best_class;

  // Accept a score whenever the queue can take a step result
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Running maximum, first class wins a tie
  assign better         = (class_idx_r == '0) || (in_score > best_score_r);
  assign cur_best_class = better ? class_idx_r : best_class_r;
  assign step_end       = class_idx_r >= cfg.blank;
  assign last_step      = step_idx_r >= cfg.last_step_idx;

  // Hand the step winner to the back
  assign q_push                = accept && step_end;
  assign q_push_data.winner    = cur_best_class;
  assign q_push_data.is_blank  = cur_best_class == cfg.blank;
  assign q_push_data.last_step = last_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_score_r <= '0;
      best_class_r <= '0;
      class_idx_r  <= '0;
      step_idx_r   <= '0;
    end else if (accept) begin
      if (better) begin
        best_score_r <= in_score;
        best_class_r <= class_idx_r;
      end
      // Advance class and step counters
      if (step_end) begin
        class_idx_r <= '0;
        step_idx_r  <= last_step ? '0 : step_idx_r + 1'b1;
      end else begin
        class_idx_r <= class_idx_r + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/ctc_queue.sv =====
module ctc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ctc_pkg::step_evt_t push_data,
  output logic               full,
  input  logic               pop,
  output ctc_pkg::step_evt_t pop_data,
  output logic               empty
);

  ctc_pkg::step_evt_t              mem_r [ctc_pkg::QUEUE_DEPTH];
  logic [ctc_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [ctc_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [ctc_pkg::QCNT_W-1:0]      count_r;

  assign full     = count_r == ctc_pkg::QCNT_W'(ctc_pkg::QUEUE_DEPTH);
  assign empty    = count_r == '0;
  assign pop_data = mem_r[rd_ptr_r];

  // Store incoming step results
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and track occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == ctc_pkg::QPTR_W'(ctc_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == ctc_pkg::QPTR_W'(ctc_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/ctc_back.sv =====
module ctc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  ctc_pkg::step_evt_t          q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ctc_pkg::CLASS_W-1:0] out_label,
  output logic                        out_label_present,
  output logic                        out_sequence_end
);

  logic                        prev_nonblank_r;
  logic [ctc_pkg::CLASS_W-1:0] prev_label_r;
  logic                        out_valid_r;
  logic [ctc_pkg::CLASS_W-1:0] out_label_r;
  logic                        out_present_r;
  logic                        out_end_r;

  logic emit;
  logic has_result;

  // Take a step result when the output register is free or being drained
  assign q_pop = !q_empty && (!out_valid_r || out_ready);

  // Greedy collapse: drop blanks and repeats of the previous winner
  assign emit       = !q_data.is_blank &&
                      !(prev_nonblank_r && (q_data.winner == prev_label_r));
  assign has_result = emit || q_data.last_step;

  // Update collapse memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_nonblank_r <= 1'b0;
      prev_label_r    <= '0;
    end else if (q_pop) begin
      if (q_data.last_step) begin
        prev_nonblank_r <= 1'b0;
        prev_label_r    <= '0;
      end else if (q_data.is_blank) begin
        prev_nonblank_r <= 1'b0;
      end else begin
        prev_nonblank_r <= 1'b1;
        prev_label_r    <= q_data.winner;
      end
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= has_result;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && has_result) begin
      out_label_r   <= emit ? q_data.winner : '0;
      out_present_r <= emit;
      out_end_r     <= q_data.last_step;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_label         = out_label_r;
  assign out_label_present = out_present_r;
  assign out_sequence_end  = out_end_r;

endmodule

// ===== tb/tb_ctc_greedy_decoder.sv =====
module tb_ctc_greedy_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 8;
  localparam int TAIL_CYCLES  = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 580;

  typedef struct packed {
    logic [ctc_pkg::CLASS_W-1:0] label;
    logic                        present;
    logic                        seq_end;
  } label_evt_t;

  logic                               clk;
  logic                               rst_n;
  logic                               psel;
  logic                               penable;
  logic                               pwrite;
  logic [ctc_pkg::ADDR_W-1:0]         paddr;
  logic [ctc_pkg::DATA_W-1:0]         pwdata;
  logic [ctc_pkg::DATA_W-1:0]         prdata;
  logic                               pready;
  logic                               in_valid;
  logic                               in_ready;
  logic signed [ctc_pkg::SCORE_W-1:0] in_score;
  logic                               out_valid;
  logic                               out_ready;
  logic [ctc_pkg::CLASS_W-1:0]        out_label;
  logic                               out_label_present;
  logic                               out_sequence_end;

  // Scores waiting to be offered and decoded labels waiting to arrive
  logic signed [ctc_pkg::SCORE_W-1:0] score_q[$];
  label_evt_t                         label_q[$];

  // Decoder state as the testbench tracks it
  logic [ctc_pkg::CLASS_COUNT_W-1:0]  cfg_classes;
  logic [ctc_pkg::STEP_COUNT_W-1:0]   cfg_steps;
  logic signed [ctc_pkg::SCORE_W-1:0] top_score;
  logic [ctc_pkg::CLASS_W-1:0]        top_class;
  logic [ctc_pkg::CLASS_W-1:0]        cls_pos;
  logic [ctc_pkg::STEP_W-1:0]         step_pos;
  logic [ctc_pkg::CLASS_W-1:0]        prev_label;
  logic                               prev_valid;

  bit tx_idle;
  bit rx_idle;
  bit hold_req;
  int plan_winner;
  int errors;
  int accepted;
  int results;
  int labels_seen;
  int seq_ends;
  int reg_writes;
  int cycles;

  ctc_greedy_decoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_score          (in_score),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_label         (out_label),
    .out_label_present (out_label_present),
    .out_sequence_end  (out_sequence_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR: %s", msg);
  endfunction

  // Append to the stimulus and expectation queues
  function automatic void add_score(input logic signed [ctc_pkg::SCORE_W-1:0] s);
    score_q.insert(score_q.size(), s);
  endfunction

  function automatic void add_label(input label_evt_t ev);
    label_q.insert(label_q.size(), ev);
  endfunction

  // Apply the register clamps
  function automatic int eff_classes();
    if (cfg_classes < 2) return 2;
    if (cfg_classes > ctc_pkg::MAX_CLASSES) return ctc_pkg::MAX_CLASSES;
    return int'(cfg_classes);
  endfunction

  function automatic int eff_steps();
    if (cfg_steps < 1) return 1;
    if (cfg_steps > ctc_pkg::MAX_STEPS) return ctc_pkg::MAX_STEPS;
    return int'(cfg_steps);
  endfunction

  // Track the running maximum and collapse the step winner into a label
  function automatic void decode_score(input logic signed [ctc_pkg::SCORE_W-1:0] s);
    int                          blank_idx;
    int                          last_idx;
    logic [ctc_pkg::CLASS_W-1:0] winner;
    logic                        emit;
    logic                        seq_done;
    label_evt_t                  ev;
    blank_idx = eff_classes() - 1;
    last_idx  = eff_steps() - 1;
    if (cls_pos == '0 || s > top_score) begin
      top_score = s;
      top_class = cls_pos;
    end
    if (int'(cls_pos) < blank_idx) begin
      cls_pos = cls_pos + 1'b1;
      return;
    end
    // Step done: blank clears the repeat memory
    winner  = top_class;
    cls_pos = '0;
    emit = (int'(winner) != blank_idx) && !(prev_valid && winner == prev_label);
    if (int'(winner) == blank_idx) begin
      prev_valid = 1'b0;
    end else begin
      prev_label = winner;
      prev_valid = 1'b1;
    end
    seq_done = int'(step_pos) >= last_idx;
    if (seq_done) begin
      step_pos   = '0;
      prev_valid = 1'b0;
      prev_label = '0;
    end else begin
      step_pos = step_pos + 1'b1;
    end
    if (emit || seq_done) begin
      ev.label   = emit ? winner : '0;
      ev.present = emit;
      ev.seq_end = seq_done;
      add_label(ev);
    end
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer queued scores; predict on each accepted transaction
  initial begin : score_source
    int gap;
    in_valid = 1'b0;
    in_score = '0;
    @(posedge clk);
    forever begin
      gap = tx_idle ? pick_gap() : 0;
      if (score_q.size() == 0 || gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        while (score_q.size() == 0) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_score <= score_q[0];
      do @(posedge clk); while (!in_ready);
      decode_score(score_q.pop_front());
      accepted++;
    end
  end

  // Stall the result side at random, or hold off for a long stretch on request
  initial begin : result_sink
    int stall;
    int run;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = rx_idle ? pick_gap() : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      run = $urandom_range(1, 8);
      repeat (run) @(posedge clk);
    end
  end

  // Compare each result transaction with the oldest expected label
  always @(posedge clk) begin
    label_evt_t ev;
    if (rst_n && out_valid && out_ready) begin
      results++;
      if (out_label_present) labels_seen++;
      if (out_sequence_end) seq_ends++;
      if (label_q.size() == 0) begin
        flag_error($sformatf("unexpected result label=%0d present=%0b end=%0b",
                             out_label, out_label_present, out_sequence_end));
      end else begin
        ev = label_q.pop_front();
        if (out_label !== ev.label || out_label_present !== ev.present ||
            out_sequence_end !== ev.seq_end)
          flag_error($sformatf("result %0d: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                               results, ev.label, ev.present, ev.seq_end,
                               out_label, out_label_present, out_sequence_end));
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycles, label_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // One configuration transaction: setup phase, then access phase until pready
  task automatic apb_access(input logic wr, input logic sel,
                            input logic [ctc_pkg::DATA_W-1:0] wdata,
                            output logic [ctc_pkg::DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ctc_pkg::ADDR_W'({sel, 2'b00});
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic sel);
    logic [ctc_pkg::DATA_W-1:0] rd;
    apb_access(1'b0, sel, '0, rd);
    if (sel == ctc_pkg::REG_CLASS_COUNT) begin
      if (rd[ctc_pkg::CLASS_COUNT_W-1:0] !== cfg_classes)
        flag_error($sformatf("class_count read: expected %0d, got %0d",
                             cfg_classes, rd[ctc_pkg::CLASS_COUNT_W-1:0]));
    end else begin
      if (rd[ctc_pkg::STEP_COUNT_W-1:0] !== cfg_steps)
        flag_error($sformatf("step_count read: expected %0d, got %0d",
                             cfg_steps, rd[ctc_pkg::STEP_COUNT_W-1:0]));
    end
  endtask

  task automatic set_reg(input logic sel, input logic [ctc_pkg::DATA_W-1:0] value);
    logic [ctc_pkg::DATA_W-1:0] rd;
    apb_access(1'b1, sel, value, rd);
    if (sel == ctc_pkg::REG_CLASS_COUNT) cfg_classes = value[ctc_pkg::CLASS_COUNT_W-1:0];
    else cfg_steps = value[ctc_pkg::STEP_COUNT_W-1:0];
    reg_writes++;
    check_reg(sel);
  endtask

  // Wait until every score is taken and every label has come out
  task automatic drain();
    while (score_q.size() != 0 || label_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Queue one step of scores, steering the winner toward blanks and repeats
  task automatic queue_step(input int n_cls);
    int mode;
    int r;
    int w;
    logic signed [ctc_pkg::SCORE_W-1:0] s;
    mode = $urandom_range(0, 9);
    r    = $urandom_range(0, 9);
    if (r < 3) w = n_cls - 1;
    else if (r < 5 && plan_winner < n_cls) w = plan_winner;
    else w = $urandom_range(0, n_cls - 1);
    plan_winner = w;
    for (int k = 0; k < n_cls; k++) begin
      if (mode < 3) s = ctc_pkg::SCORE_W'($urandom);
      else if (mode < 5)
        s = ctc_pkg::SCORE_W'($urandom_range(0, 4)) - ctc_pkg::SCORE_W'(2);
      else if (k == w) s = ctc_pkg::SCORE_W'($urandom_range(0, 32767));
      else s = -ctc_pkg::SCORE_W'($urandom_range(1, 32768));
      add_score(s);
    end
  endtask

  task automatic test_register_defaults();
    check_reg(ctc_pkg::REG_CLASS_COUNT);
    check_reg(ctc_pkg::REG_STEP_COUNT);
    set_reg(ctc_pkg::REG_CLASS_COUNT, 32'd4);
    set_reg(ctc_pkg::REG_STEP_COUNT, 32'd3);
  endtask

  // Four classes, three steps: extremes, ties, repeats, blanks and sequence ends
  task automatic test_directed();
    int pat [24];
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    pat = '{32767, -32768, 0, -1,        // class 0 wins, label
            -32768, 5, 5, 0,             // tie goes to the lower class
            -1, 100, -5, -32768,         // repeat suppressed, sequence ends
            0, 0, 0, 0,                  // all equal, memory cleared
            -100, -100, -100, 50,        // blank wins, no result
            10, -3, -3, -3};             // same label again across the blank
    foreach (pat[k]) add_score(ctc_pkg::SCORE_W'(pat[k]));
    drain();
  endtask

  // Shrink the counts under running counters so they are already passed
  task automatic test_mid_sequence_config();
    set_reg(ctc_pkg::REG_CLASS_COUNT, 32'd10);
    set_reg(ctc_pkg::REG_STEP_COUNT, 32'd6);
    queue_step(10);
    for (int k = 0; k < 6; k++)
      add_score(ctc_pkg::SCORE_W'(($urandom_range(0, 9) * 997) % 4000));
    drain();
    set_reg(ctc_pkg::REG_CLASS_COUNT, 32'd4);
    add_score(ctc_pkg::SCORE_W'($urandom));
    queue_step(4);
    queue_step(4);
    drain();
    set_reg(ctc_pkg::REG_STEP_COUNT, 32'd3);
    queue_step(4);
    queue_step(4);
    drain();
  endtask

  // Clamped and extreme register values, upper write bits ignored
  task automatic test_config_extremes();
    logic [ctc_pkg::DATA_W-1:0] raw_c;
    logic [ctc_pkg::DATA_W-1:0] raw_s;
    int n_steps;
    for (int k = 0; k < 7; k++) begin
      case (k)
        0: begin raw_c = 32'd0;         raw_s = 32'd0;         n_steps = 3;  end
        1: begin raw_c = 32'd1;         raw_s = 32'd63;        n_steps = 34; end
        2: begin raw_c = 32'd255;       raw_s = 32'd1;         n_steps = 1;  end
        3: begin raw_c = 32'd128;       raw_s = 32'd33;        n_steps = 1;  end
        4: begin raw_c = 32'd129;       raw_s = 32'd32;        n_steps = 1;  end
        5: begin raw_c = 32'hFFFF_FF02; raw_s = 32'hFFFF_FFC5; n_steps = 6;  end
        default: begin raw_c = 32'd2;   raw_s = 32'd32;        n_steps = 33; end
      endcase
      set_reg(ctc_pkg::REG_CLASS_COUNT, raw_c);
      set_reg(ctc_pkg::REG_STEP_COUNT, raw_s);
      for (int j = 0; j < n_steps; j++) queue_step(eff_classes());
      drain();
    end
  endtask

  // Hold the result side off while scores keep coming so the input stalls
  task automatic test_backpressure();
    set_reg(ctc_pkg::REG_CLASS_COUNT, 32'd2);
    set_reg(ctc_pkg::REG_STEP_COUNT, 32'd5);
    tx_idle  = 1'b0;
    rx_idle  = 1'b0;
    hold_req = 1'b1;
    for (int j = 0; j < 40; j++) queue_step(2);
    drain();
  endtask

  task automatic test_random();
    int start;
    int r;
    int n_steps;
    int n_cls;
    start = accepted;
    while (accepted - start < RANDOM_ITEMS) begin
      drain();
      r = $urandom_range(0, 19);
      if (r == 0)
        set_reg(ctc_pkg::REG_CLASS_COUNT, ctc_pkg::DATA_W'($urandom_range(126, 255)));
      else if (r == 1)
        set_reg(ctc_pkg::REG_CLASS_COUNT, ctc_pkg::DATA_W'($urandom_range(0, 1)));
      else if (r < 14)
        set_reg(ctc_pkg::REG_CLASS_COUNT, ctc_pkg::DATA_W'($urandom_range(2, 12)));
      r = $urandom_range(0, 9);
      if (r == 0)
        set_reg(ctc_pkg::REG_STEP_COUNT, ctc_pkg::DATA_W'($urandom_range(30, 63)));
      else if (r < 7)
        set_reg(ctc_pkg::REG_STEP_COUNT, ctc_pkg::DATA_W'($urandom_range(0, 8)));
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      n_cls   = eff_classes();
      n_steps = (n_cls >= 64) ? $urandom_range(1, 2) : $urandom_range(2, 12);
      for (int j = 0; j < n_steps; j++) queue_step(n_cls);
      // Sometimes stop mid-step so the next write lands inside a step
      if ($urandom_range(0, 4) == 0)
        for (int j = $urandom_range(1, n_cls - 1); j > 0; j--)
          add_score(ctc_pkg::SCORE_W'($urandom));
      while (score_q.size() != 0) @(posedge clk);
    end
  endtask

  initial begin : run
    rst_n       = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    cfg_classes = ctc_pkg::CLASS_COUNT_RESET;
    cfg_steps   = ctc_pkg::STEP_COUNT_RESET;
    top_score   = '0;
    top_class   = '0;
    cls_pos     = '0;
    step_pos    = '0;
    prev_label  = '0;
    prev_valid  = 1'b0;
    plan_winner = 0;
    tx_idle     = 1'b1;
    rx_idle     = 1'b1;
    hold_req    = 1'b0;
    errors      = 0;
    accepted    = 0;
    results     = 0;
    labels_seen = 0;
    seq_ends    = 0;
    reg_writes  = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_defaults();
    test_directed();
    test_mid_sequence_config();
    test_config_extremes();
    test_backpressure();
    test_random();

    // Let the pipeline empty, then watch for stray results
    while (score_q.size() != 0 || label_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Decoded %0d scores into %0d results (%0d labels, %0d sequence ends)",
             accepted, results, labels_seen, seq_ends);
    $display("Covered %0d register writes, clamped counts, mid-sequence updates, %s",
             reg_writes, "long output hold-off and random gaps");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ctc_pkg.sv
rtl/ctc_front.sv
rtl/ctc_queue.sv
rtl/ctc_back.sv
rtl/ctc_greedy_decoder.sv
tb/tb_ctc_greedy_decoder.sv
